// ----- hw/rtl/xild_pkg.sv -----
// shared types, opcode constants and length functions for the x86 class/length decoder
package xild_pkg;

  localparam logic [7:0] REX_LO     = 8'h48;
  localparam logic [7:0] REX_HI     = 8'h4F;
  localparam logic [7:0] OP_NOP     = 8'h90;
  localparam logic [7:0] OP_ESC     = 8'h0F;
  localparam logic [7:0] OP_MNOP    = 8'h1F;
  localparam logic [3:0] HI_JCCNEAR = 4'h8;
  localparam logic [3:0] HI_CMOV    = 4'h4;
  localparam logic [7:0] OP_PREF    = 8'h18;
  localparam logic [7:0] OP_RET     = 8'hC3;
  localparam logic [7:0] OP_JMPS    = 8'hEB;
  localparam logic [7:0] OP_JMPN    = 8'hE9;
  localparam logic [3:0] HI_JCCS    = 4'h7;
  localparam logic [5:0] HI_MOV     = 6'b100010;
  localparam logic [7:0] OP_REP     = 8'hF3;
  localparam logic [7:0] OP_STOSB   = 8'hAA;

  typedef enum logic [3:0] {
    CLS_UNKNOWN  = 4'd0,
    CLS_REXFALL  = 4'd1,
    CLS_NOP      = 4'd2,
    CLS_MULTINOP = 4'd3,
    CLS_JCCNEAR  = 4'd4,
    CLS_CMOV     = 4'd5,
    CLS_PREFETCH = 4'd6,
    CLS_OTHER0F  = 4'd7,
    CLS_RET      = 4'd8,
    CLS_JMPSHORT = 4'd9,
    CLS_JMPNEAR  = 4'd10,
    CLS_JCCSHORT = 4'd11,
    CLS_MOV      = 4'd12,
    CLS_REPSTOSB = 4'd13,
    CLS_REPOTHER = 4'd14
  } insn_class_t;

  // after rex extraction
  typedef struct packed {
    logic       rex;
    logic [2:0] rex_bits;
    logic [7:0] op;
    logic [7:0] nx1;
    logic [7:0] nx2;
  } s1_t;

  // after opcode match
  typedef struct packed {
    logic       rex;
    logic [2:0] rex_bits;
    logic [7:0] op;
    logic [3:0] cc_op;
    logic [3:0] cc_nx1;
    logic       nop;
    logic       esc;
    logic       mnop;
    logic       jccnear;
    logic       cmov;
    logic       pref;
    logic       ret;
    logic       jmps;
    logic       jmpn;
    logic       jccs;
    logic       mov;
    logic       rep;
    logic       stosb;
    logic [3:0] len_mnop;
    logic [3:0] len_mov;
  } s2_t;

  typedef struct packed {
    logic [3:0] insn_class;
    logic [3:0] insn_length;
    logic [3:0] cond_code;
    logic       rex_found;
    logic [2:0] rex_bits;
    logic [7:0] opcode_byte;
  } res_t;

  function automatic logic [3:0] mnop_len(input logic [7:0] modrm);
    logic [1:0] md;
    logic [2:0] rm;
    logic [3:0] len;
    md  = modrm[7:6];
    rm  = modrm[2:0];
    len = 4'd3;
    if (md == 2'd1 && rm == 3'd0) len = 4'd4;
    if (md == 2'd1 && rm == 3'd4) len = 4'd5;
    if (md == 2'd2 && rm == 3'd0) len = 4'd7;
    if (md == 2'd2 && rm == 3'd4) len = 4'd8;
    return len;
  endfunction

  function automatic logic [3:0] mov_len(input logic [7:0] modrm);
    logic [1:0] md;
    logic [2:0] rm;
    logic [3:0] len;
    md  = modrm[7:6];
    rm  = modrm[2:0];
    len = 4'd2;
    if (md == 2'd1) len = len + 4'd1;
    if (md == 2'd2) len = len + 4'd4;
    if (md == 2'd0 && rm == 3'd5) len = len + 4'd4;
    if (md != 2'd3 && rm == 3'd4) len = len + 4'd1;
    return len;
  endfunction

endpackage

// ----- hw/rtl/xild_in_if.sv -----
// input channel carrying a four-byte instruction window
interface xild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  input ready);
  modport sink   (input valid, input byte0, input byte1, input byte2, input byte3,
                  output ready);
endinterface

// ----- hw/rtl/xild_out_if.sv -----
// output channel carrying one decoded instruction word
interface xild_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] insn_class;
  logic [3:0] insn_length;
  logic [3:0] cond_code;
  logic       rex_found;
  logic [2:0] rex_bits;
  logic [7:0] opcode_byte;

  modport source (output valid, output insn_class, output insn_length, output cond_code,
                  output rex_found, output rex_bits, output opcode_byte, input ready);
  modport sink   (input valid, input insn_class, input insn_length, input cond_code,
                  input rex_found, input rex_bits, input opcode_byte, output ready);
endinterface

// ----- hw/rtl/xild_core.sv -----
// opcode match and class/length select stages of the decoder
module xild_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          s1_valid,
  input  xild_pkg::s1_t s1,
  output logic          res_valid,
  output xild_pkg::res_t res
);
  import xild_pkg::*;

  s2_t  s2_next;
  s2_t  s2;
  logic v2;
  res_t res_next;

  always_comb begin
    s2_next          = '0;
    s2_next.rex      = s1.rex;
    s2_next.rex_bits = s1.rex_bits;
    s2_next.op       = s1.op;
    s2_next.cc_op    = s1.op[3:0];
    s2_next.cc_nx1   = s1.nx1[3:0];
    s2_next.nop      = (s1.op == OP_NOP) && !s1.rex;
    s2_next.esc      = (s1.op == OP_ESC);
    s2_next.mnop     = (s1.nx1 == OP_MNOP);
    s2_next.jccnear  = (s1.nx1[7:4] == HI_JCCNEAR);
    s2_next.cmov     = (s1.nx1[7:4] == HI_CMOV);
    s2_next.pref     = (s1.nx1 == OP_PREF) && (s1.nx2[5:3] == 3'd0);
    s2_next.ret      = (s1.op == OP_RET) && !s1.rex;
    s2_next.jmps     = (s1.op == OP_JMPS);
    s2_next.jmpn     = (s1.op == OP_JMPN);
    s2_next.jccs     = (s1.op[7:4] == HI_JCCS);
    s2_next.mov      = (s1.op[7:2] == HI_MOV);
    s2_next.rep      = (s1.op == OP_REP);
    s2_next.stosb    = (s1.nx1 == OP_STOSB);
    s2_next.len_mnop = mnop_len(s1.nx2);
    s2_next.len_mov  = mov_len(s1.nx1);
  end

  always_comb begin
    insn_class_t cls;
    logic [3:0]  len;
    logic [3:0]  cc;
    cls = s2.rex ? CLS_REXFALL : CLS_UNKNOWN;
    len = 4'd1;
    cc  = 4'd0;
    if (s2.nop) begin
      cls = CLS_NOP;      len = 4'd1;
    end else if (s2.esc) begin
      if (s2.mnop) begin
        cls = CLS_MULTINOP; len = s2.len_mnop;
      end else if (s2.jccnear) begin
        cls = CLS_JCCNEAR;  len = 4'd6; cc = s2.cc_nx1;
      end else if (s2.cmov) begin
        cls = CLS_CMOV;     len = 4'd3; cc = s2.cc_nx1;
      end else if (s2.pref) begin
        cls = CLS_PREFETCH; len = 4'd3;
      end else begin
        cls = CLS_OTHER0F;  len = 4'd2;
      end
    end else if (s2.ret) begin
      cls = CLS_RET;      len = 4'd1;
    end else if (s2.jmps) begin
      cls = CLS_JMPSHORT; len = 4'd2;
    end else if (s2.jmpn) begin
      cls = CLS_JMPNEAR;  len = 4'd5;
    end else if (s2.jccs) begin
      cls = CLS_JCCSHORT; len = 4'd2; cc = s2.cc_op;
    end else if (s2.mov) begin
      cls = CLS_MOV;      len = s2.len_mov;
    end else if (s2.rep && s2.stosb) begin
      cls = CLS_REPSTOSB; len = 4'd2;
    end else if (s2.rep) begin
      cls = CLS_REPOTHER; len = 4'd2;
    end
    res_next.insn_class  = cls;
    res_next.insn_length = len + {3'd0, s2.rex};
    res_next.cond_code   = cc;
    res_next.rex_found   = s2.rex;
    res_next.rex_bits    = s2.rex_bits;
    res_next.opcode_byte = s2.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v2        <= s1_valid;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= s2_next;
      res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/x86_insn_class_length_decode_unit.sv -----
// top level of the x86-64 instruction class and length decoder
// an accepted window is registered in s1, then s2, then the result word
// throughput: one word per cycle; all stages advance together when the output is free
// a stalled output holds every stage, so nothing is lost or repeated
// reset: synchronous, clears the stage valid bits only
module x86_insn_class_length_decode_unit (
  input  logic  clk,
  input  logic  rst,
  xild_in_if.sink    insn,
  xild_out_if.source result
);
  import xild_pkg::*;

  logic en;
  logic v1;
  s1_t  s1_next;
  s1_t  s1;
  logic res_valid;
  res_t res;

  assign en         = !res_valid || result.ready;
  assign insn.ready = en;

  always_comb begin
    s1_next.rex      = (insn.byte0 >= REX_LO) && (insn.byte0 <= REX_HI);
    s1_next.rex_bits = s1_next.rex ? insn.byte0[2:0] : 3'd0;
    s1_next.op       = s1_next.rex ? insn.byte1 : insn.byte0;
    s1_next.nx1      = s1_next.rex ? insn.byte2 : insn.byte1;
    s1_next.nx2      = s1_next.rex ? insn.byte3 : insn.byte2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= insn.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  xild_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s1_valid  (v1),
    .s1        (s1),
    .res_valid (res_valid),
    .res       (res)
  );

  assign result.valid       = res_valid;
  assign result.insn_class  = res.insn_class;
  assign result.insn_length = res.insn_length;
  assign result.cond_code   = res.cond_code;
  assign result.rex_found   = res.rex_found;
  assign result.rex_bits    = res.rex_bits;
  assign result.opcode_byte = res.opcode_byte;

endmodule

// ----- sim/xild_decode_checker.sv -----
// checker for the x86 class/length decoder: predicts each result word and compares it
module xild_decode_checker (
  input  logic clk,
  input  logic rst,
  xild_in_if   insn,
  xild_out_if  result,
  output int   fail_count,
  output int   pending,
  output int   words_checked,
  output int   classes_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import xild_pkg::*;

  res_t        decoded_q[$];
  int          errs = 0;
  int          checked = 0;
  logic [14:0] class_seen = '0;

  function automatic res_t decode_window(input logic [7:0] w0, w1, w2, w3);
    logic        rex;
    logic [7:0]  op;
    logic [7:0]  m1;
    logic [7:0]  m2;
    insn_class_t cls;
    logic [3:0]  len;
    logic [3:0]  cc;
    logic [1:0]  md;
    logic [2:0]  rm;
    res_t        r;
    rex = (w0 >= REX_LO) && (w0 <= REX_HI);
    op  = rex ? w1 : w0;
    m1  = rex ? w2 : w1;
    m2  = rex ? w3 : w2;
    cc  = 4'd0;
    if (op == OP_NOP && !rex) begin
      cls = CLS_NOP;
      len = 4'd1;
    end else if (op == OP_ESC) begin
      if (m1 == OP_MNOP) begin
        cls = CLS_MULTINOP;
        case ({m2[7:6], m2[2:0]})
          {2'd1, 3'd0}: len = 4'd4;
          {2'd1, 3'd4}: len = 4'd5;
          {2'd2, 3'd0}: len = 4'd7;
          {2'd2, 3'd4}: len = 4'd8;
          default:      len = 4'd3;
        endcase
      end else if (m1[7:4] == HI_JCCNEAR) begin
        cls = CLS_JCCNEAR;
        len = 4'd6;
        cc  = m1[3:0];
      end else if (m1[7:4] == HI_CMOV) begin
        cls = CLS_CMOV;
        len = 4'd3;
        cc  = m1[3:0];
      end else if (m1 == OP_PREF && m2[5:3] == 3'd0) begin
        cls = CLS_PREFETCH;
        len = 4'd3;
      end else begin
        cls = CLS_OTHER0F;
        len = 4'd2;
      end
    end else if (op == OP_RET && !rex) begin
      cls = CLS_RET;
      len = 4'd1;
    end else if (op == OP_JMPS) begin
      cls = CLS_JMPSHORT;
      len = 4'd2;
    end else if (op == OP_JMPN) begin
      cls = CLS_JMPNEAR;
      len = 4'd5;
    end else if (op[7:4] == HI_JCCS) begin
      cls = CLS_JCCSHORT;
      len = 4'd2;
      cc  = op[3:0];
    end else if (op[7:2] == HI_MOV) begin
      cls = CLS_MOV;
      md  = m1[7:6];
      rm  = m1[2:0];
      case (md)
        2'd0:    len = (rm == 3'd5) ? 4'd6 : 4'd2;
        2'd1:    len = 4'd3;
        2'd2:    len = 4'd6;
        default: len = 4'd2;
      endcase
      // sib byte only with a memory operand
      if (md != 2'd3 && rm == 3'd4) len = len + 4'd1;
    end else if (op == OP_REP) begin
      cls = (m1 == OP_STOSB) ? CLS_REPSTOSB : CLS_REPOTHER;
      len = 4'd2;
    end else begin
      cls = rex ? CLS_REXFALL : CLS_UNKNOWN;
      len = 4'd1;
    end
    r.insn_class  = cls;
    r.insn_length = len + {3'd0, rex};
    r.cond_code   = cc;
    r.rex_found   = rex;
    r.rex_bits    = rex ? w0[2:0] : 3'd0;
    r.opcode_byte = op;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (rst) begin
      decoded_q.delete();
    end else begin
      if (insn.valid && insn.ready)
        decoded_q.push_back(decode_window(insn.byte0, insn.byte1, insn.byte2, insn.byte3));
      if (result.valid && result.ready) begin
        got.insn_class  = result.insn_class;
        got.insn_length = result.insn_length;
        got.cond_code   = result.cond_code;
        got.rex_found   = result.rex_found;
        got.rex_bits    = result.rex_bits;
        got.opcode_byte = result.opcode_byte;
        if (decoded_q.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual %0h", $time, got);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          check_field("insn_class", 8'(want.insn_class), 8'(got.insn_class));
          check_field("insn_length", 8'(want.insn_length), 8'(got.insn_length));
          check_field("cond_code", 8'(want.cond_code), 8'(got.cond_code));
          check_field("rex_found", 8'(want.rex_found), 8'(got.rex_found));
          check_field("rex_bits", 8'(want.rex_bits), 8'(got.rex_bits));
          check_field("opcode_byte", want.opcode_byte, got.opcode_byte);
          checked++;
          class_seen[want.insn_class] = 1'b1;
        end
      end
    end
    fail_count    <= errs;
    pending       <= decoded_q.size();
    words_checked <= checked;
    classes_seen  <= $countones(class_seen);
  end

endmodule

// ----- sim/tb_x86_insn_class_length_decode_unit.sv -----
// testbench top for the x86 class/length decoder: stimulus, receiver stalls and verdict
module tb_x86_insn_class_length_decode_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import xild_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   sent_count = 0;
  int   fail_count;
  int   pending;
  int   words_checked;
  int   classes_seen;
  bit   held_off = 1'b0;

  xild_in_if  insn ();
  xild_out_if result ();

  x86_insn_class_length_decode_unit dut (
    .clk    (clk),
    .rst    (rst),
    .insn   (insn),
    .result (result)
  );

  xild_decode_checker chk (
    .clk           (clk),
    .rst           (rst),
    .insn          (insn),
    .result        (result),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .classes_seen  (classes_seen)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long, none during the burst window
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (sent_count >= 250 && sent_count < 320) return 0;
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_window();
    logic [7:0] w[4];
    bit         rex;
    int         p;
    for (int i = 0; i < 4; i++) w[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) begin
      rex = 1'($urandom_range(0, 1));
      p   = rex;
      if (rex) w[0] = {REX_LO[7:3], w[0][2:0]};
      case ($urandom_range(0, 9))
        0: w[p] = OP_NOP;
        1: w[p] = OP_RET;
        2: w[p] = OP_JMPS;
        3: w[p] = OP_JMPN;
        4: w[p] = {HI_JCCS, w[p][3:0]};
        5: begin
          w[p] = {HI_MOV, w[p][1:0]};
          if ($urandom_range(0, 1)) w[p+1][2:0] = 3'($urandom_range(4, 5));
        end
        6: begin
          w[p] = OP_REP;
          if ($urandom_range(0, 1)) w[p+1] = OP_STOSB;
        end
        default: begin
          w[p] = OP_ESC;
          case ($urandom_range(0, 4))
            0: begin
              w[p+1] = OP_MNOP;
              if ($urandom_range(0, 1)) w[p+2][2:0] = {1'($urandom_range(0, 1)), 2'b00};
            end
            1: w[p+1] = {HI_JCCNEAR, w[p+1][3:0]};
            2: w[p+1] = {HI_CMOV, w[p+1][3:0]};
            3: begin
              w[p+1] = OP_PREF;
              if ($urandom_range(0, 1)) w[p+2][5:3] = 3'd0;
            end
            default: ;
          endcase
        end
      endcase
    end
    return {w[0], w[1], w[2], w[3]};
  endfunction

  task automatic send_window(input logic [7:0] b0, b1, b2, b3);
    int gap;
    insn.valid <= 1'b1;
    insn.byte0 <= b0;
    insn.byte1 <= b1;
    insn.byte2 <= b2;
    insn.byte3 <= b3;
    do @(posedge clk); while (!insn.ready);
    sent_count++;
    gap = idle_len();
    if (gap > 0) begin
      insn.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : receiver
    result.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!held_off && sent_count >= 150) begin
        // long hold-off so the pipeline fills and stalls the input
        held_off = 1'b1;
        result.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (sent_count < 250 || sent_count >= 320) begin
        if ($urandom_range(0, 3) == 0) begin
          result.ready <= 1'b0;
          repeat (idle_len() + 1) @(posedge clk);
        end else begin
          result.ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] w;
    rst        <= 1'b1;
    insn.valid <= 1'b0;
    insn.byte0 <= 8'h00;
    insn.byte1 <= 8'h00;
    insn.byte2 <= 8'h00;
    insn.byte3 <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_window(OP_NOP, 8'h00, 8'h00, 8'h00);
    send_window(REX_LO, OP_NOP, 8'h00, 8'h00);
    send_window(OP_RET, 8'hFF, 8'hFF, 8'hFF);
    send_window(REX_HI, OP_RET, 8'h00, 8'h00);
    send_window(OP_ESC, OP_MNOP, 8'h00, 8'h00);
    send_window(OP_ESC, OP_MNOP, 8'h40, 8'h00);
    send_window(OP_ESC, OP_MNOP, 8'h44, 8'h00);
    send_window(OP_ESC, OP_MNOP, 8'h80, 8'h00);
    send_window(REX_LO, OP_ESC, OP_MNOP, 8'h84);
    send_window(OP_ESC, OP_MNOP, 8'hC0, 8'h00);
    send_window(OP_ESC, {HI_JCCNEAR, 4'hF}, 8'h00, 8'h00);
    send_window(8'h4A, OP_ESC, {HI_CMOV, 4'h0}, 8'h00);
    send_window(OP_ESC, OP_PREF, 8'h08, 8'h00);
    send_window(OP_ESC, OP_PREF, 8'hC7, 8'h00);
    send_window(OP_ESC, 8'hFF, 8'h00, 8'h00);
    send_window(OP_JMPS, 8'h00, 8'h00, 8'h00);
    send_window(REX_HI, OP_JMPN, 8'hFF, 8'hFF);
    send_window({HI_JCCS, 4'h0}, 8'h00, 8'h00, 8'h00);
    send_window({HI_JCCS, 4'hF}, 8'hFF, 8'h00, 8'h00);
    send_window({HI_MOV, 2'b00}, 8'h04, 8'h00, 8'h00);
    send_window({HI_MOV, 2'b11}, 8'h05, 8'h00, 8'h00);
    send_window({HI_MOV, 2'b01}, 8'hC4, 8'h00, 8'h00);
    send_window(REX_HI, {HI_MOV, 2'b10}, 8'h84, 8'h00);
    send_window(OP_REP, OP_STOSB, 8'h00, 8'h00);
    send_window(8'h4C, OP_REP, 8'h00, 8'h00);
    send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_window(8'h4D, 8'hFF, 8'h00, 8'h00);

    for (int i = 0; i < 375; i++) begin
      w = random_window();
      send_window(w[31:24], w[23:16], w[15:8], w[7:0]);
    end
    insn.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("decoded %0d windows, %0d result words checked, %0d of 15 classes seen",
             sent_count, words_checked, classes_seen);
    $display("run included a long output stall with the input backed up");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d words outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
